// ----- design/lobm_pkg.sv -----
// lobm_pkg: shared request codes, status codes and the queued work item
// for the order book matcher; no dependencies
`default_nettype none

package lobm_pkg;

   localparam int PRICE_W = 8;
   localparam int VOL_W   = 32;

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD_BID = 2'd0,
      REQ_ADD_ASK = 2'd1,
      REQ_MATCH   = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_code_type;

   // result status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_REJECT   = 2'd1;
   localparam logic [1:0] ST_NO_CROSS = 2'd2;

   // classified request as it travels from the front to the back
   typedef struct packed {
      req_code_type       code;
      logic               price_ok;
      logic [PRICE_W-1:0] price;
      logic [VOL_W-1:0]   volume;
   } work_item_type;

endpackage

`default_nettype wire

// ----- design/lobm_ram.sv -----
// lobm_ram: generic single write port, single read port ram with
// registered read data; no dependencies
`default_nettype none

module lobm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/lobm_front.sv -----
// lobm_front: accepts request words, checks the price range and holds them
// in a two entry queue for the back end; depends on lobm_pkg
`default_nettype none

module lobm_front #(
   parameter int PRICE_LEVELS = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_type,
   input  wire logic [lobm_pkg::PRICE_W-1:0]  req_price,
   input  wire logic [lobm_pkg::VOL_W-1:0]    req_volume,
   output logic                               q_valid,
   input  wire logic                          q_ready,
   output lobm_pkg::work_item_type            q_item
);
   import lobm_pkg::*;

   work_item_type slot_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    fill_ff;
   work_item_type item_in;
   logic          push, pop;

   // classify the incoming word
   always_comb begin
      item_in.code     = req_code_type'(req_type);
      item_in.price_ok = (32'(req_price) < PRICE_LEVELS);
      item_in.price    = req_price;
      item_in.volume   = req_volume;
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // queue storage and pointers
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

`default_nettype wire

// ----- design/lobm_back.sv -----
// lobm_back: executes adds, matches and clears against the level and
// volume memories, re-finds best prices and drives the result register;
// depends on lobm_pkg and lobm_ram
`default_nettype none

module lobm_back #(
   parameter int PRICE_LEVELS      = 256,
   parameter int LEVEL_QUEUE_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   output logic                               q_ready,
   input  wire lobm_pkg::work_item_type       q_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [lobm_pkg::VOL_W-1:0]         rsp_trade_volume,
   output logic                               rsp_best_bid_valid,
   output logic [lobm_pkg::PRICE_W-1:0]       rsp_best_bid,
   output logic                               rsp_best_ask_valid,
   output logic [lobm_pkg::PRICE_W-1:0]       rsp_best_ask
);
   import lobm_pkg::*;

   localparam int PW     = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
   localparam int HW     = (LEVEL_QUEUE_DEPTH > 1) ? $clog2(LEVEL_QUEUE_DEPTH) : 1;
   localparam int CW     = $clog2(LEVEL_QUEUE_DEPTH + 1);
   localparam int SW     = CW + 1;
   localparam int LW     = HW + CW;
   localparam int VDEPTH = PRICE_LEVELS * LEVEL_QUEUE_DEPTH;
   localparam int VAW    = $clog2(VDEPTH);
   localparam int GRP    = 16;
   localparam int NG     = (PRICE_LEVELS + GRP - 1) / GRP;
   localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
   localparam int PADW   = NG * GRP;
   localparam logic [CW-1:0] CNT_FULL = CW'(LEVEL_QUEUE_DEPTH);
   localparam logic [SW-1:0] SUM_WRAP = SW'(LEVEL_QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_ADD_RD, S_ADD_WR, S_M_LV, S_M_VOL, S_M_EXE, S_SRCH1, S_SRCH2
   } state_type;

   state_type           st_ff;
   work_item_type       item_ff;
   logic [1:0]          status_ff;
   logic [VOL_W-1:0]    traded_ff;
   logic [PRICE_LEVELS-1:0] occ_bid_ff, occ_ask_ff;
   logic [PW-1:0]       bb_ff, ba_ff;
   logic                bbv_ff, bav_ff;
   logic [GW-1:0]       grp_bid_ff, grp_ask_ff;
   logic                grpv_bid_ff, grpv_ask_ff;
   logic [HW-1:0]       bid_head_ff, ask_head_ff;
   logic [CW-1:0]       bid_cnt_ff, ask_cnt_ff;
   logic [VAW-1:0]      bid_vaddr_ff, ask_vaddr_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [VOL_W-1:0]    rsp_trade_ff;
   logic                rsp_bbv_ff, rsp_bav_ff;
   logic [PRICE_W-1:0]  rsp_bb_ff, rsp_ba_ff;
   logic                rsp_load;

   // memory ports
   logic                bl_we, al_we, bl_re, bv_we, av_we, bv_re;
   logic [PW-1:0]       bl_waddr, al_waddr, bl_raddr, al_raddr;
   logic [LW-1:0]       bl_wdata, al_wdata, bl_rdata, al_rdata;
   logic [VAW-1:0]      bv_waddr, av_waddr, bv_raddr, av_raddr;
   logic [VOL_W-1:0]    bv_wdata, av_wdata, bv_rdata, av_rdata;

   function automatic logic [VAW-1:0] vol_addr(input logic [PW-1:0] p,
                                               input logic [HW-1:0] s);
      return VAW'(int'(p) * LEVEL_QUEUE_DEPTH + int'(s));
   endfunction

   function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
      return (int'(h) == LEVEL_QUEUE_DEPTH - 1) ? '0 : HW'(int'(h) + 1);
   endfunction

   // add path: level lookup, slot and fullness
   logic          side_ask, cur_occ, add_ok;
   logic [PW-1:0] pidx;
   logic [HW-1:0] head_e, slot_h;
   logic [CW-1:0] cnt_e;
   logic [SW-1:0] slot_sum;

   always_comb begin
      side_ask = (item_ff.code == REQ_ADD_ASK);
      pidx     = PW'(item_ff.price);
      cur_occ  = side_ask ? occ_ask_ff[pidx] : occ_bid_ff[pidx];
      head_e   = cur_occ ? (side_ask ? al_rdata[LW-1:CW] : bl_rdata[LW-1:CW]) : '0;
      cnt_e    = cur_occ ? (side_ask ? al_rdata[CW-1:0] : bl_rdata[CW-1:0]) : '0;
      add_ok   = item_ff.price_ok && (cnt_e != CNT_FULL);
      slot_sum = SW'(head_e) + SW'(cnt_e);
      if (slot_sum >= SUM_WRAP) begin
         slot_sum = slot_sum - SUM_WRAP;
      end
      slot_h   = HW'(slot_sum);
   end

   // match path: trade and front order pops
   logic [VOL_W-1:0] traded, new_bvol, new_avol;
   logic             pop_b, pop_a;
   logic [CW-1:0]    bcnt_n, acnt_n;
   logic [HW-1:0]    bhead_n, ahead_n;

   always_comb begin
      traded   = (bv_rdata < av_rdata) ? bv_rdata : av_rdata;
      new_bvol = bv_rdata - traded;
      new_avol = av_rdata - traded;
      pop_b    = (new_bvol == '0);
      pop_a    = (new_avol == '0);
      bcnt_n   = bid_cnt_ff - CW'(1);
      acnt_n   = ask_cnt_ff - CW'(1);
      bhead_n  = (bcnt_n == '0) ? '0 : head_inc(bid_head_ff);
      ahead_n  = (acnt_n == '0) ? '0 : head_inc(ask_head_ff);
   end

   // memory addressing
   always_comb begin
      bl_re    = (st_ff == S_ADD_RD) || (st_ff == S_M_LV);
      bl_raddr = (st_ff == S_M_LV) ? bb_ff : pidx;
      al_raddr = (st_ff == S_M_LV) ? ba_ff : pidx;
      bv_re    = (st_ff == S_M_VOL);
      bv_raddr = vol_addr(bb_ff, bl_rdata[LW-1:CW]);
      av_raddr = vol_addr(ba_ff, al_rdata[LW-1:CW]);

      bl_we    = ((st_ff == S_ADD_WR) && !side_ask && add_ok) ||
                 ((st_ff == S_M_EXE) && pop_b);
      al_we    = ((st_ff == S_ADD_WR) && side_ask && add_ok) ||
                 ((st_ff == S_M_EXE) && pop_a);
      bl_waddr = (st_ff == S_M_EXE) ? bb_ff : pidx;
      al_waddr = (st_ff == S_M_EXE) ? ba_ff : pidx;
      bl_wdata = (st_ff == S_M_EXE) ? {bhead_n, bcnt_n} : {head_e, cnt_e + CW'(1)};
      al_wdata = (st_ff == S_M_EXE) ? {ahead_n, acnt_n} : {head_e, cnt_e + CW'(1)};

      bv_we    = ((st_ff == S_ADD_WR) && !side_ask && add_ok) || (st_ff == S_M_EXE);
      av_we    = ((st_ff == S_ADD_WR) && side_ask && add_ok) || (st_ff == S_M_EXE);
      bv_waddr = (st_ff == S_M_EXE) ? bid_vaddr_ff : vol_addr(pidx, slot_h);
      av_waddr = (st_ff == S_M_EXE) ? ask_vaddr_ff : vol_addr(pidx, slot_h);
      bv_wdata = (st_ff == S_M_EXE) ? new_bvol : item_ff.volume;
      av_wdata = (st_ff == S_M_EXE) ? new_avol : item_ff.volume;
   end

   lobm_ram #(.WIDTH(LW), .DEPTH(PRICE_LEVELS)) u_bid_level (
      .clock, .wr_en(bl_we), .wr_addr(bl_waddr), .wr_data(bl_wdata),
      .rd_en(bl_re), .rd_addr(bl_raddr), .rd_data(bl_rdata));
   lobm_ram #(.WIDTH(LW), .DEPTH(PRICE_LEVELS)) u_ask_level (
      .clock, .wr_en(al_we), .wr_addr(al_waddr), .wr_data(al_wdata),
      .rd_en(bl_re), .rd_addr(al_raddr), .rd_data(al_rdata));
   lobm_ram #(.WIDTH(VOL_W), .DEPTH(VDEPTH)) u_bid_vol (
      .clock, .wr_en(bv_we), .wr_addr(bv_waddr), .wr_data(bv_wdata),
      .rd_en(bv_re), .rd_addr(bv_raddr), .rd_data(bv_rdata));
   lobm_ram #(.WIDTH(VOL_W), .DEPTH(VDEPTH)) u_ask_vol (
      .clock, .wr_en(av_we), .wr_addr(av_waddr), .wr_data(av_wdata),
      .rd_en(bv_re), .rd_addr(av_raddr), .rd_data(av_rdata));

   // best price search, first the group then the tick inside it
   logic [PADW-1:0] bid_pad, ask_pad;
   logic [NG-1:0]   grp_or_b, grp_or_a;
   logic [GW-1:0]   grp_b, grp_a;
   logic [GRP-1:0]  win_b, win_a;
   logic [PW-1:0]   best_b, best_a;

   always_comb begin
      bid_pad = PADW'(occ_bid_ff);
      ask_pad = PADW'(occ_ask_ff);
      grp_b   = '0;
      grp_a   = '0;
      for (int g = 0; g < NG; g++) begin
         grp_or_b[g] = |bid_pad[g*GRP +: GRP];
         grp_or_a[g] = |ask_pad[g*GRP +: GRP];
      end
      for (int g = 0; g < NG; g++) begin
         if (grp_or_b[g]) grp_b = GW'(g);
      end
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_or_a[g]) grp_a = GW'(g);
      end
      win_b  = bid_pad[int'(grp_bid_ff)*GRP +: GRP];
      win_a  = ask_pad[int'(grp_ask_ff)*GRP +: GRP];
      best_b = '0;
      best_a = '0;
      for (int l = 0; l < GRP; l++) begin
         if (win_b[l]) best_b = PW'(int'(grp_bid_ff) * GRP + l);
      end
      for (int l = GRP - 1; l >= 0; l--) begin
         if (win_a[l]) best_a = PW'(int'(grp_ask_ff) * GRP + l);
      end
   end

   assign q_ready  = (st_ff == S_IDLE);
   assign rsp_load = (st_ff == S_SRCH2) && (!rsp_valid_ff || rsp_ready);

   // sequencer, book occupancy and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         occ_bid_ff   <= '0;
         occ_ask_ff   <= '0;
         bbv_ff       <= 1'b0;
         bav_ff       <= 1'b0;
         bb_ff        <= '0;
         ba_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff   <= q_item;
                  traded_ff <= '0;
                  unique case (q_item.code)
                     REQ_ADD_BID, REQ_ADD_ASK: begin
                        status_ff <= ST_DONE;
                        st_ff     <= S_ADD_RD;
                     end
                     REQ_MATCH: begin
                        if (bbv_ff && bav_ff && (bb_ff >= ba_ff)) begin
                           status_ff <= ST_DONE;
                           st_ff     <= S_M_LV;
                        end else begin
                           status_ff <= ST_NO_CROSS;
                           st_ff     <= S_SRCH1;
                        end
                     end
                     REQ_CLEAR: begin
                        status_ff  <= ST_DONE;
                        occ_bid_ff <= '0;
                        occ_ask_ff <= '0;
                        st_ff      <= S_SRCH1;
                     end
                     default: begin
                        status_ff <= ST_DONE;
                        st_ff     <= S_SRCH1;
                     end
                  endcase
               end
            end
            S_ADD_RD: st_ff <= S_ADD_WR;
            S_ADD_WR: begin
               if (add_ok) begin
                  if (side_ask) occ_ask_ff[pidx] <= 1'b1;
                  else          occ_bid_ff[pidx] <= 1'b1;
               end else begin
                  status_ff <= ST_REJECT;
               end
               st_ff <= S_SRCH1;
            end
            S_M_LV: st_ff <= S_M_VOL;
            S_M_VOL: begin
               bid_head_ff  <= bl_rdata[LW-1:CW];
               bid_cnt_ff   <= bl_rdata[CW-1:0];
               ask_head_ff  <= al_rdata[LW-1:CW];
               ask_cnt_ff   <= al_rdata[CW-1:0];
               bid_vaddr_ff <= bv_raddr;
               ask_vaddr_ff <= av_raddr;
               st_ff        <= S_M_EXE;
            end
            S_M_EXE: begin
               traded_ff <= traded;
               if (pop_b && (bcnt_n == '0)) occ_bid_ff[bb_ff] <= 1'b0;
               if (pop_a && (acnt_n == '0)) occ_ask_ff[ba_ff] <= 1'b0;
               st_ff <= S_SRCH1;
            end
            S_SRCH1: begin
               grp_bid_ff  <= grp_b;
               grp_ask_ff  <= grp_a;
               grpv_bid_ff <= |grp_or_b;
               grpv_ask_ff <= |grp_or_a;
               st_ff       <= S_SRCH2;
            end
            S_SRCH2: begin
               if (rsp_load) begin
                  bbv_ff        <= grpv_bid_ff;
                  bav_ff        <= grpv_ask_ff;
                  bb_ff         <= grpv_bid_ff ? best_b : '0;
                  ba_ff         <= grpv_ask_ff ? best_a : '0;
                  rsp_status_ff <= status_ff;
                  rsp_trade_ff  <= traded_ff;
                  rsp_bbv_ff    <= grpv_bid_ff;
                  rsp_bav_ff    <= grpv_ask_ff;
                  rsp_bb_ff     <= grpv_bid_ff ? PRICE_W'(best_b) : '0;
                  rsp_ba_ff     <= grpv_ask_ff ? PRICE_W'(best_a) : '0;
                  st_ff         <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_trade_volume   = rsp_trade_ff;
   assign rsp_best_bid_valid = rsp_bbv_ff;
   assign rsp_best_bid       = rsp_bb_ff;
   assign rsp_best_ask_valid = rsp_bav_ff;
   assign rsp_best_ask       = rsp_ba_ff;

endmodule

`default_nettype wire

// ----- design/limit_order_book_matcher_core.sv -----
// limit_order_book_matcher_core: price-time priority order book top level
// depends on lobm_pkg, lobm_front, lobm_back and lobm_ram
//
// usage
//   req channel (valid/ready): one word per request; req_type selects add bid,
//   add ask, match once or clear both books; req_price and req_volume feed adds
//   rsp channel (valid/ready): exactly one word per request, in order, with the
//   status, traded volume and the best bid and ask after that request
// timing
//   a two-word queue takes requests while the back end runs one at a time
//   through the level and volume memories and a group-then-tick best-price
//   search; an add reads then writes its level, a crossing match reads the
//   levels, the volumes, then executes, and other requests go to the search
//   directly; a queued request is taken only after the result is loaded
// reset and stalls
//   reset empties both books, the queue and the result register; memories keep
//   stale contents, which are never used before being written
//   while rsp_ready is low the finished word is held, the next request waits in
//   its search step and up to two more requests queue up before req_ready drops
`default_nettype none

module limit_order_book_matcher_core #(
   parameter int PRICE_LEVELS      = 256,
   parameter int LEVEL_QUEUE_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_type,
   input  wire logic [lobm_pkg::PRICE_W-1:0]  req_price,
   input  wire logic [lobm_pkg::VOL_W-1:0]    req_volume,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [lobm_pkg::VOL_W-1:0]         rsp_trade_volume,
   output logic                               rsp_best_bid_valid,
   output logic [lobm_pkg::PRICE_W-1:0]       rsp_best_bid,
   output logic                               rsp_best_ask_valid,
   output logic [lobm_pkg::PRICE_W-1:0]       rsp_best_ask
);
   import lobm_pkg::*;

   logic          q_valid, q_ready;
   work_item_type q_item;

   // request intake and queue
   lobm_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_price,
      .req_volume, .q_valid, .q_ready, .q_item);

   // execution and results
   lobm_back #(
      .PRICE_LEVELS(PRICE_LEVELS), .LEVEL_QUEUE_DEPTH(LEVEL_QUEUE_DEPTH)
   ) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item, .rsp_valid, .rsp_ready,
      .rsp_status, .rsp_trade_volume, .rsp_best_bid_valid, .rsp_best_bid,
      .rsp_best_ask_valid, .rsp_best_ask);

   // only a successful match moves volume
   a_trade_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> (rsp_trade_volume == '0))
      else $error("trade volume reported on a failed request");

   // an empty bid book reports tick zero
   a_empty_bid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_best_bid_valid) |-> (rsp_best_bid == '0))
      else $error("empty bid book reports a nonzero tick");

   // status is always one of the three defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_DONE) || (rsp_status == ST_REJECT) ||
                     (rsp_status == ST_NO_CROSS)))
      else $error("undefined status code");

   // result word stays out of reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

`default_nettype wire
